>>> rtl/bei_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bei_pkg
// Shared types and constants for the breakpoint envelope interpolator.
// ----------------------------------------------------------------------------
package bei_pkg;

   localparam int VAL_BITS      = 16;   // Q8.8 value width
   localparam int CNT_BITS      = 4;    // step counter of the multiply/divide unit
   localparam int COUNT_BITS    = 7;    // point_count register width
   localparam int IDX_BITS      = 6;    // point_index field width
   localparam int EXT_TIME_BITS = 32;   // time fields on the ports
   localparam int OP_BITS       = 2;

   localparam logic [OP_BITS-1:0] OP_WRITE  = 2'd0;
   localparam logic [OP_BITS-1:0] OP_EVAL   = 2'd1;
   localparam logic [OP_BITS-1:0] OP_REWIND = 2'd2;

   typedef logic signed [VAL_BITS-1:0] value_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_WALK,
      ST_SEG,
      ST_CALC,
      ST_PUT
   } state_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV
   } md_state_type;

endpackage

>>> rtl/breakpoint_envelope_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// breakpoint_envelope_interpolator
// Piecewise-linear envelope over a breakpoint table held in one RAM.
// ----------------------------------------------------------------------------
// An evaluation reads the first and last points, walks the cursor forward over the
// segments it passes, and then settles its segment directly or through the
// multiply/divide unit; an empty table or a query at either end returns early.
// The result becomes valid in the same cycle that the next request can be taken;
// one request is in work at a time, a result may wait at the output.
// Synchronous reset clears point_count, the cursor and the handshakes; not the table.
module breakpoint_envelope_interpolator #(
   parameter int MAX_POINTS = 64,
   parameter int TIME_BITS  = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bei_pkg::OP_BITS-1:0]       req_op,
   input  logic [bei_pkg::IDX_BITS-1:0]      req_point_index,
   input  logic [bei_pkg::EXT_TIME_BITS-1:0] req_point_time,
   input  logic signed [bei_pkg::VAL_BITS-1:0] req_point_value,
   input  logic [bei_pkg::EXT_TIME_BITS-1:0] req_query_time,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [bei_pkg::VAL_BITS-1:0] rsp_env_value,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bei_pkg::COUNT_BITS-1:0]    csr_point_count
);

   import bei_pkg::*;

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int NW = $clog2(MAX_POINTS + 1);
   localparam int XW = (NW > COUNT_BITS) ? NW : COUNT_BITS;
   localparam int DW = TIME_BITS + VAL_BITS;

   state_type             state_ff,  state_in;
   logic [COUNT_BITS-1:0] count_ff,  count_in;
   logic [AW-1:0]         cursor_ff, cursor_in;
   logic [NW-1:0]         n_ff,      n_in;
   logic [TIME_BITS-1:0]  q_ff,      q_in;
   logic [TIME_BITS-1:0]  tb_ff,     tb_in;
   value_type             vb_ff,     vb_in;
   value_type             va_ff,     va_in;
   logic                  neg_ff,    neg_in;
   value_type             res_ff,    res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   value_type             rsp_value_ff, rsp_value_in;

   logic                  accept;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [DW-1:0]         wr_data;
   logic [AW-1:0]         rd_addr;
   logic [DW-1:0]         rd_data;
   logic [TIME_BITS-1:0]  rd_time;
   value_type             rd_value;

   logic                  md_start;
   logic [VAL_BITS-1:0]   md_mag;
   logic [TIME_BITS-1:0]  md_dt;
   logic [TIME_BITS-1:0]  md_span;
   logic                  md_done;
   logic [VAL_BITS-1:0]   md_quo;

   logic [NW-1:0]         seg_lim;
   logic [AW-1:0]         cur_clamp;
   logic signed [VAL_BITS:0] diff;
   logic [VAL_BITS:0]     diff_neg;
   logic [VAL_BITS:0]     sum;

   bei_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_POINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bei_muldiv #(
      .TIME_BITS (TIME_BITS)
   ) u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (md_start),
      .mag   (md_mag),
      .dt    (md_dt),
      .span  (md_span),
      .done  (md_done),
      .quo   (md_quo)
   );

   assign rd_time  = rd_data[DW-1:VAL_BITS];
   assign rd_value = rd_data[VAL_BITS-1:0];

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && !req_stall;

   assign wr_addr = AW'(req_point_index);
   assign wr_data = {TIME_BITS'(req_point_time), req_point_value};
   assign wr_en   = accept && (req_op == OP_WRITE) &&
                    (XW'(req_point_index) < XW'(MAX_POINTS));

   // segment a = cursor pulled back inside the last segment
   assign seg_lim   = n_ff - NW'(2);
   assign cur_clamp = (NW'(cursor_ff) > seg_lim) ? AW'(seg_lim) : cursor_ff;

   assign diff     = {vb_ff[VAL_BITS-1], vb_ff} - {rd_value[VAL_BITS-1], rd_value};
   assign diff_neg = -diff;
   assign md_mag   = diff[VAL_BITS] ? diff_neg[VAL_BITS-1:0] : diff[VAL_BITS-1:0];
   assign md_dt    = q_ff - rd_time;
   assign md_span  = tb_ff - rd_time;

   assign sum = neg_ff ? ({va_ff[VAL_BITS-1], va_ff} - {1'b0, md_quo})
                       : ({va_ff[VAL_BITS-1], va_ff} + {1'b0, md_quo});

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cursor_in    = cursor_ff;
      n_in         = n_ff;
      q_in         = q_ff;
      tb_in        = tb_ff;
      vb_in        = vb_ff;
      va_in        = va_ff;
      neg_in       = neg_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rd_addr      = '0;
      md_start     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_WRITE, OP_REWIND: begin
                     cursor_in = '0;
                  end
                  OP_EVAL: begin
                     q_in = TIME_BITS'(req_query_time);
                     if (XW'(count_ff) > XW'(MAX_POINTS)) begin
                        n_in = NW'(MAX_POINTS);
                     end else begin
                        n_in = NW'(count_ff);
                     end
                     if (count_ff == '0) begin
                        res_in   = '0;
                        state_in = ST_PUT;
                     end else begin
                        rd_addr  = '0;
                        state_in = ST_FIRST;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            if (csr_valid) begin
               count_in  = csr_point_count;
               cursor_in = '0;
            end
         end
         ST_FIRST: begin
            if ((n_ff == NW'(1)) || (q_ff <= rd_time)) begin
               res_in   = rd_value;
               state_in = ST_PUT;
            end else begin
               rd_addr  = AW'(n_ff - NW'(1));
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            if (q_ff >= rd_time) begin
               res_in   = rd_value;
               state_in = ST_PUT;
            end else begin
               cursor_in = cur_clamp;
               rd_addr   = cur_clamp + AW'(1);
               state_in  = ST_WALK;
            end
         end
         ST_WALK: begin
            // rd_data holds the point at cursor+1
            if (((NW'(cursor_ff) + NW'(1)) < (n_ff - NW'(1))) && (q_ff > rd_time)) begin
               cursor_in = cursor_ff + AW'(1);
               rd_addr   = cursor_ff + AW'(2);
            end else begin
               tb_in    = rd_time;
               vb_in    = rd_value;
               rd_addr  = cursor_ff;
               state_in = ST_SEG;
            end
         end
         ST_SEG: begin
            // rd_data holds the point at cursor
            if (tb_ff <= rd_time) begin
               res_in   = vb_ff;
               state_in = ST_PUT;
            end else if (q_ff <= rd_time) begin
               res_in   = rd_value;
               state_in = ST_PUT;
            end else if (q_ff >= tb_ff) begin
               res_in   = vb_ff;
               state_in = ST_PUT;
            end else begin
               va_in    = rd_value;
               neg_in   = diff[VAL_BITS];
               md_start = 1'b1;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (md_done) begin
               res_in   = sum[VAL_BITS-1:0];
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      q_ff         <= q_in;
      tb_ff        <= tb_in;
      vb_ff        <= vb_in;
      va_ff        <= va_in;
      neg_ff       <= neg_in;
      res_ff       <= res_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_env_value = rsp_value_ff;

endmodule

>>> rtl/bei_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bei_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bei_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/bei_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bei_muldiv
// Computes mag * dt / span, truncated, by 16 shift-add steps followed by
// 16 restoring division steps. Needs dt < span so the quotient fits 16 bits.
// ----------------------------------------------------------------------------
module bei_muldiv #(
   parameter int TIME_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bei_pkg::VAL_BITS-1:0] mag,
   input  logic [TIME_BITS-1:0]         dt,
   input  logic [TIME_BITS-1:0]         span,
   output logic                         done,
   output logic [bei_pkg::VAL_BITS-1:0] quo
);

   import bei_pkg::*;

   localparam int PW = TIME_BITS + VAL_BITS;

   md_state_type         state_ff,  state_in;
   logic [CNT_BITS-1:0]  cnt_ff,    cnt_in;
   logic [PW-1:0]        acc_ff,    acc_in;
   logic [PW-1:0]        sh_ff,     sh_in;
   logic [VAL_BITS-1:0]  mag_ff,    mag_in;
   logic [TIME_BITS-1:0] span_ff,   span_in;
   logic [VAL_BITS-1:0]  quo_ff,    quo_in;
   logic                 done_ff,   done_in;
   logic                 last_step;

   assign last_step = (cnt_ff == CNT_BITS'(VAL_BITS - 1));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      sh_in    = sh_ff;
      mag_in   = mag_ff;
      span_in  = span_ff;
      quo_in   = quo_ff;
      done_in  = 1'b0;
      case (state_ff)
         MD_IDLE: begin
            if (start) begin
               mag_in   = mag;
               sh_in    = PW'(dt);
               span_in  = span;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = MD_MUL;
            end
         end
         MD_MUL: begin
            if (mag_ff[0]) begin
               acc_in = acc_ff + sh_ff;
            end
            mag_in = mag_ff >> 1;
            sh_in  = sh_ff << 1;
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (last_step) begin
               // divisor starts at span aligned to the top quotient bit
               sh_in    = PW'(span_ff) << (VAL_BITS - 1);
               cnt_in   = '0;
               state_in = MD_DIV;
            end
         end
         MD_DIV: begin
            if (acc_ff >= sh_ff) begin
               acc_in = acc_ff - sh_ff;
               quo_in = {quo_ff[VAL_BITS-2:0], 1'b1};
            end else begin
               quo_in = {quo_ff[VAL_BITS-2:0], 1'b0};
            end
            sh_in  = sh_ff >> 1;
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (last_step) begin
               done_in  = 1'b1;
               state_in = MD_IDLE;
            end
         end
         default: begin
            state_in = MD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      sh_ff   <= sh_in;
      mag_ff  <= mag_in;
      span_ff <= span_in;
      quo_ff  <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for breakpoint_envelope_interpolator. Point writes,
// evaluations, rewinds and the unused op are driven through the request
// channel with random idling. An in-bench model of the breakpoint table and
// its forward-only cursor predicts each envelope value, and every returned
// value is compared in order against it. point_count is reprogrammed between
// phases, including empty, single-point, full and saturated tables.
// ----------------------------------------------------------------------------
module tb;
   import bei_pkg::*;

   localparam int CLK_PERIOD     = 8;
   localparam int TABLE_DEPTH    = 64;
   localparam int SETTLE_CYCLES  = 120;    // longest evaluation walks the whole table
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_ITEMS   = 430;
   localparam int IDLE_PERCENT   = 37;
   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [OP_BITS-1:0]       req_op = OP_REWIND;
   logic [IDX_BITS-1:0]      req_point_index = '0;
   logic [EXT_TIME_BITS-1:0] req_point_time = '0;
   value_type                req_point_value = '0;
   logic [EXT_TIME_BITS-1:0] req_query_time = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   value_type                rsp_env_value;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [COUNT_BITS-1:0]    csr_point_count = '0;

   // bench copy of the block state
   logic [31:0]  time_mem [TABLE_DEPTH];
   value_type    value_mem [TABLE_DEPTH];
   int unsigned  walk_cursor = 0;
   int unsigned  points_in_use = 0;
   int unsigned  phase_slots = 0;

   value_type    pending_env_values[$];
   int unsigned  error_count = 0;
   int unsigned  items_accepted = 0;
   int unsigned  useful_items = 0;
   int unsigned  values_checked = 0;
   int unsigned  count_writes = 0;
   int unsigned  holdoff_request = 0;
   int unsigned  idle_cycles = 0;
   bit           steady_flow = 1'b0;

   breakpoint_envelope_interpolator i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_point_index (req_point_index),
      .req_point_time  (req_point_time),
      .req_point_value (req_point_value),
      .req_query_time  (req_query_time),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_env_value   (rsp_env_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_point_count (csr_point_count)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("ERROR @%0t: %s", $time, what);
      error_count++;
   endtask

   function automatic value_type segment_value(input int unsigned a, input logic [31:0] q);
      logic [31:0]     ta, tb;
      int              va, vb, diff;
      longint unsigned mag, dt, span, quo;
      ta = time_mem[a];
      tb = time_mem[a + 1];
      va = value_mem[a];
      vb = value_mem[a + 1];
      if (tb <= ta) return value_type'(vb);
      if (q <= ta) return value_type'(va);
      if (q >= tb) return value_type'(vb);
      diff = vb - va;
      mag  = (diff < 0) ? longint'(-diff) : longint'(diff);
      dt   = q - ta;
      span = tb - ta;
      quo  = (mag * dt) / span;
      return (diff < 0) ? value_type'(va - int'(quo)) : value_type'(va + int'(quo));
   endfunction

   function automatic value_type envelope_at(input logic [31:0] q);
      int unsigned n;
      n = (points_in_use > TABLE_DEPTH) ? TABLE_DEPTH : points_in_use;
      if (n == 0) return '0;
      if (n == 1 || q <= time_mem[0]) return value_mem[0];
      if (q >= time_mem[n - 1]) return value_mem[n - 1];
      if (walk_cursor > n - 2) walk_cursor = n - 2;
      while (walk_cursor + 1 < n - 1 && q > time_mem[walk_cursor + 1]) walk_cursor++;
      return segment_value(walk_cursor, q);
   endfunction

   task automatic send_request(input logic [OP_BITS-1:0] op, input logic [IDX_BITS-1:0] idx,
                               input logic [31:0] pt, input value_type pv,
                               input logic [31:0] qt);
      while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_op          <= op;
      req_point_index <= idx;
      req_point_time  <= pt;
      req_point_value <= pv;
      req_query_time  <= qt;
      req_valid       <= 1'b1;
      do @(posedge clock); while (req_stall);
      items_accepted++;
      if (op != OP_UNUSED) useful_items++;
      case (op)
         OP_WRITE: begin
            time_mem[idx]  = pt;
            value_mem[idx] = pv;
            walk_cursor    = 0;
         end
         OP_EVAL:   pending_env_values.push_back(envelope_at(qt));
         OP_REWIND: walk_cursor = 0;
         default: ;
      endcase
   endtask

   task automatic send_write(input int unsigned idx, input logic [31:0] pt, input value_type pv);
      send_request(OP_WRITE, idx[IDX_BITS-1:0], pt, pv, $urandom);
   endtask

   task automatic send_eval(input logic [31:0] qt);
      send_request(OP_EVAL, IDX_BITS'($urandom), $urandom, value_type'($urandom), qt);
   endtask

   task automatic send_control(input logic [OP_BITS-1:0] op);
      send_request(op, IDX_BITS'($urandom), $urandom, value_type'($urandom), $urandom);
   endtask

   // request side quiet and every value back, then room for a walk still in flight
   task automatic settle_idle();
      req_valid <= 1'b0;
      while (pending_env_values.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_point_count(input logic [COUNT_BITS-1:0] count);
      settle_idle();
      csr_point_count <= count;
      csr_valid       <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid     <= 1'b0;
      points_in_use  = count;
      walk_cursor    = 0;
      count_writes++;
   endtask

   task automatic load_breakpoints(input int unsigned slots);
      longint unsigned t_now, max_step;
      int unsigned     span_bits, r;
      logic [31:0]     t_slot;
      value_type       v_slot;
      span_bits = $urandom_range(6, 32);
      max_step  = ((64'd1 << span_bits) / (slots + 1)) + 1;
      t_now     = ($urandom_range(3) == 0) ? 0 : ({32'd0, $urandom} >> (33 - span_bits));
      for (int unsigned i = 0; i < slots; i++) begin
         r = $urandom_range(99);
         if (r < 6 || i == 0) begin
            t_slot = t_now[31:0];                 // repeats the previous time
         end else if (r < 10) begin
            t_slot = t_now[31:0] >> 1;            // out of order
         end else begin
            t_now += $urandom_range(1, int'(max_step));
            if (t_now > 64'hFFFF_FFFF) t_now = 64'hFFFF_FFFF;
            t_slot = t_now[31:0];
         end
         r = $urandom_range(99);
         v_slot = (r < 10) ? 16'sh8000 : (r < 20) ? 16'sh7FFF : value_type'($urandom);
         send_write(i, t_slot, v_slot);
      end
   endtask

   task automatic start_phase(input logic [COUNT_BITS-1:0] count);
      write_point_count(count);
      phase_slots = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
      load_breakpoints(phase_slots);
   endtask

   // mostly forward-moving queries over the loaded span, with noise mixed in
   task automatic run_ops(input int unsigned n_ops);
      longint unsigned lo, hi, qpos, stride;
      int unsigned     r, slot;
      lo = 0;
      hi = 64'hFFFF_FFFF;
      if (phase_slots > 0) begin
         lo = time_mem[0];
         hi = time_mem[phase_slots - 1];
         if (hi < lo) hi = lo;
         lo = (lo > 1000) ? lo - $urandom_range(0, 1000) : 0;
         hi = hi + $urandom_range(0, 1000);
         if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
      end
      stride = (hi - lo) / n_ops + 1;
      qpos   = lo;
      repeat (n_ops) begin
         r = $urandom_range(99);
         if (r < 66) begin
            qpos += stride * $urandom_range(0, 200) / 100;
            if (qpos > hi) qpos = hi;
            send_eval(qpos[31:0]);
         end else if (r < 74) begin
            send_eval($urandom);
         end else if (r < 82) begin
            send_control(OP_REWIND);
            qpos = lo;
         end else if (r < 86) begin
            send_control(OP_UNUSED);
         end else if (r < 92) begin
            if (phase_slots > 0) begin
               slot = $urandom_range(0, phase_slots - 1);
               send_write(slot, $urandom_range(1) ? time_mem[slot] : $urandom,
                          value_type'($urandom));
            end else begin
               send_write($urandom_range(0, TABLE_DEPTH - 1), $urandom, value_type'($urandom));
            end
         end else begin
            if (phase_slots > 0) send_eval(time_mem[$urandom_range(0, phase_slots - 1)]);
            else send_eval($urandom);
         end
      end
   endtask

   task automatic test_empty_table();
      write_point_count(0);
      send_eval(32'h0000_0000);
      send_eval(32'hFFFF_FFFF);
      send_control(OP_UNUSED);
      send_control(OP_REWIND);
   endtask

   task automatic test_single_point();
      write_point_count(1);
      send_write(0, 32'h8000_0000, 16'sh7FFF);
      send_eval(32'h0000_0000);
      send_eval(32'hFFFF_FFFF);
   endtask

   task automatic test_segments();
      write_point_count(3);
      send_write(0, 32'd100, 16'sh8000);
      send_write(1, 32'd1000, 16'sh7FFF);
      send_write(2, 32'hFFFF_FFFF, -16'sd1);
      send_eval(32'd0);
      send_eval(32'd100);
      send_eval(32'd550);
      send_eval(32'd1000);
      send_eval(32'd2000);
      send_eval(32'd500);              // behind the cursor, no rewind
      send_control(OP_REWIND);
      send_eval(32'd500);
      send_eval(32'hFFFF_FFFE);
      send_eval(32'hFFFF_FFFF);
   endtask

   task automatic test_coincident_points();
      write_point_count(4);
      send_write(0, 32'd0, 16'sh0100);
      send_write(1, 32'd50, -16'sh0100);
      send_write(2, 32'd50, 16'sh7FFF);
      send_write(3, 32'd100, 16'sh8000);
      send_eval(32'd50);
      send_eval(32'd75);
      send_eval(32'd25);
   endtask

   task automatic test_back_pressure();
      start_phase(8);
      holdoff_request = 400;
      run_ops(30);
   endtask

   task automatic test_full_table_burst();
      steady_flow = 1'b1;
      start_phase(TABLE_DEPTH);
      run_ops(80);
      steady_flow = 1'b0;
   endtask

   task automatic test_saturated_count();
      start_phase(7'd127);
      run_ops(30);
   endtask

   task automatic test_random_phases();
      int unsigned first_item, r;
      logic [COUNT_BITS-1:0] count;
      first_item = useful_items;
      while (useful_items - first_item < RANDOM_ITEMS) begin
         r = $urandom_range(99);
         if (r < 4)       count = 0;
         else if (r < 8)  count = 1;
         else if (r < 13) count = TABLE_DEPTH;
         else if (r < 17) count = COUNT_BITS'($urandom_range(TABLE_DEPTH + 1, 127));
         else             count = COUNT_BITS'($urandom_range(2, 10));
         start_phase(count);
         run_ops((count >= TABLE_DEPTH) ? 50 : $urandom_range(8, 24));
      end
   endtask

   // result side: check in order, then pick the stall for the next cycle
   always @(posedge clock) begin : rsp_side
      value_type   want;
      int unsigned holdoff_left;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_env_values.size() == 0) begin
            report_mismatch($sformatf("env_value %0d returned with none pending",
                                      rsp_env_value));
         end else begin
            want = pending_env_values.pop_front();
            values_checked++;
            if (rsp_env_value !== want)
               report_mismatch($sformatf("env_value got %0d, want %0d", rsp_env_value, want));
         end
      end
      if (holdoff_request != 0) begin
         holdoff_left    = holdoff_request;
         holdoff_request = 0;
      end
      if (holdoff_left != 0) begin
         holdoff_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady_flow && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d values outstanding",
                  idle_cycles, pending_env_values.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_single_point();
      test_segments();
      test_coincident_points();
      test_back_pressure();
      test_full_table_burst();
      test_saturated_count();
      test_random_phases();
      settle_idle();
      $display("Covered %0d requests and %0d checked envelope values over %0d point_count writes,",
               items_accepted, values_checked, count_writes);
      $display("with empty, single, full and saturated tables and a long result hold-off.");
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", error_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/bei_pkg.sv
rtl/bei_ram.sv
rtl/bei_muldiv.sv
rtl/breakpoint_envelope_interpolator.sv
sim/tb.sv
